// ===== src/mm3_pkg.sv =====
`timescale 1ns / 1ps

package mm3_pkg;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned COUNT_W = 30;

	localparam logic [WORD_W-1:0] C1_MUL  = 32'hCC9E2D51;
	localparam logic [WORD_W-1:0] C2_MUL  = 32'h1B873593;
	localparam logic [WORD_W-1:0] MIX_ADD = 32'hE6546B64;
	localparam logic [WORD_W-1:0] FMIX_M1 = 32'h85EBCA6B;
	localparam logic [WORD_W-1:0] FMIX_M2 = 32'hC2B2AE35;

	localparam int unsigned ROT_K = 15;
	localparam int unsigned ROT_H = 13;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL2,
		ST_MIX,
		ST_FIN1,
		ST_FIN2
	} mm3_state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;   // take input beat, first scramble multiply
		logic mul2;   // rotate and second scramble multiply
		logic mix;    // fold into running hash, bump count
		logic fin1;   // length fold and first fmix multiply, reload seed
		logic fin2;   // second fmix multiply into output register
	} mm3_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic last;
	} mm3_status_t;

	// mod 2^32 product
	function automatic logic [WORD_W-1:0] mul32(input logic [WORD_W-1:0] a,
		input logic [WORD_W-1:0] b);
		logic [2*WORD_W-1:0] p;
		p = a * b;
		return p[WORD_W-1:0];
	endfunction

endpackage

// ===== src/mm3_ctrl.sv =====
`timescale 1ns / 1ps

module mm3_ctrl import mm3_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	output logic        out_valid,
	input  logic        out_stall,
	input  mm3_status_t status,
	output mm3_cmd_t    cmd
);

	mm3_state_t state_q, state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_MUL2;
			ST_MUL2: state_d = ST_MIX;
			ST_MIX:  state_d = status.last ? ST_FIN1 : ST_IDLE;
			ST_FIN1: state_d = ST_FIN2;
			ST_FIN2: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_MUL2: cmd.mul2 = 1'b1;
			ST_MIX:  cmd.mix  = 1'b1;
			ST_FIN1: cmd.fin1 = 1'b1;
			ST_FIN2: cmd.fin2 = out_free;
			default: in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.fin2)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== src/mm3_datapath.sv =====
`timescale 1ns / 1ps

module mm3_datapath import mm3_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  mm3_cmd_t          cmd,
	output mm3_status_t       status,
	input  logic [WORD_W-1:0] data_word,
	input  logic              last_word,
	input  logic              cfg_wr_en,
	input  logic [WORD_W-1:0] cfg_wr_data,
	output logic [WORD_W-1:0] hash_value
);

	logic [WORD_W-1:0]  seed_q;
	logic [WORD_W-1:0]  hash_q;
	logic [COUNT_W-1:0] count_q;
	logic               last_q;
	logic [WORD_W-1:0]  k_q;
	logic [WORD_W-1:0]  f_q;
	logic [WORD_W-1:0]  hash_value_q;

	logic [WORD_W-1:0]  k_rot, h_x, h_rot, h_mix;
	logic [WORD_W-1:0]  f_in, f_mid, f_out;

	assign k_rot = (k_q << ROT_K) | (k_q >> (WORD_W - ROT_K));
	assign h_x   = hash_q ^ k_q;
	assign h_rot = (h_x << ROT_H) | (h_x >> (WORD_W - ROT_H));
	assign h_mix = (h_rot << 2) + h_rot + MIX_ADD;

	// length fold uses the already incremented count
	always_comb begin
		f_in  = hash_q ^ {count_q, 2'b00};
		f_in  = f_in ^ (f_in >> 16);
		f_mid = f_q ^ (f_q >> 13);
		f_out = mul32(f_mid, FMIX_M2);
		f_out = f_out ^ (f_out >> 16);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q  <= '0;
			hash_q  <= '0;
			count_q <= '0;
		end else begin
			if (cfg_wr_en)
				seed_q <= cfg_wr_data;
			if (cmd.mix) begin
				hash_q  <= h_mix;
				count_q <= count_q + COUNT_W'(1);
			end else if (cmd.fin1) begin
				hash_q  <= seed_q;
				count_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			k_q    <= mul32(data_word, C1_MUL);
			last_q <= last_word;
		end else if (cmd.mul2) begin
			k_q <= mul32(k_rot, C2_MUL);
		end
		if (cmd.fin1)
			f_q <= mul32(f_in, FMIX_M1);
		if (cmd.fin2)
			hash_value_q <= f_out;
	end

	assign status.last = last_q;
	assign hash_value  = hash_value_q;

endmodule

// ===== src/murmur3_32_stream_hash_core.sv =====
`timescale 1ns / 1ps

// MurmurHash3 x86_32 over a stream of 32-bit words.
// Input channel: in_valid / in_stall with data_word and last_word. A beat
// is taken when in_valid is high and in_stall low. One word at a time is
// in flight; each word runs a scramble multiply, a second scramble
// multiply and a hash mix in turn, ordered by the chain of dependent 32x32
// multiplies through one controller/datapath pair.
// A beat with last_word high closes the message: the FIN1 and FIN2 states
// then run the fmix32 finalizer, so the hash appears on out_valid /
// hash_value when FIN2 completes; input is free again in that same cycle.
// Output channel: out_valid / out_stall. The result sits in an output
// register; the next message can be streamed in while it waits. If the
// receiver is still stalling when a new hash is done, the core holds in
// its last finalizer step (input stalled) until the register frees up.
// cfg_wr_en / cfg_wr_data write the seed; the seed is loaded into the
// running hash when a message finishes, so write it between messages.
// Reset (arst_n low, async): seed, running hash and count clear to zero,
// no result is pending and the core is ready for a beat.

module murmur3_32_stream_hash_core import mm3_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [WORD_W-1:0] data_word,
	input  logic              last_word,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [WORD_W-1:0] hash_value,
	input  logic              cfg_wr_en,
	input  logic [WORD_W-1:0] cfg_wr_data
);

	mm3_cmd_t    cmd;
	mm3_status_t status;

	// sequencing: IDLE -> MUL2 -> MIX [-> FIN1 -> FIN2]
	mm3_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// multiplier chain, running hash, word count, seed and output register
	mm3_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.data_word   (data_word),
		.last_word   (last_word),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.hash_value  (hash_value)
	);

endmodule

// ===== src/mm3_checker.sv =====
`timescale 1ns / 1ps

module mm3_checker import mm3_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              last_word,
	input logic              out_valid,
	input logic              out_stall,
	input logic [WORD_W-1:0] hash_value
);

	// one word in flight: stall right after a beat is taken
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a word is in flight");

	// a plain word frees the input once its hash mix is done
	a_word_rate: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !last_word |=> ##2 !in_stall)
		else $error("plain word did not finish in three cycles");

	// a last word still holds the input during finalization
	a_fin_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last_word |=> ##3 in_stall)
		else $error("input freed before finalization");

	// a new result only shows up out of finalization
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared while input idle");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hash_value))
		else $error("stalled result changed");

endmodule

bind murmur3_32_stream_hash_core mm3_checker u_mm3_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.last_word  (last_word),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.hash_value (hash_value)
);
